### rtl/pel_pkg.sv
// package for the palette expand and lookup block
// types, register and command codes, channel expansion table and shading helper
// no dependencies
package pel_pkg;

  localparam int unsigned ColourW = 32;
  localparam int unsigned ChanW   = 5;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned EntryW  = 12;

  typedef enum logic [1:0] {
    CFG_RED_SHIFT   = 2'd0,
    CFG_GREEN_SHIFT = 2'd1,
    CFG_BLUE_SHIFT  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [ShiftW-1:0] red;
    logic [ShiftW-1:0] green;
    logic [ShiftW-1:0] blue;
  } shift_cfg_t;

  // x*255/31, truncated
  localparam logic [7:0] EXPAND5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  function automatic logic [7:0] expand5(input logic [ChanW-1:0] x);
    return EXPAND5_LUT[x];
  endfunction

  // v*202/256, truncated
  function automatic logic [7:0] shade8(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd202;
    return p[15:8];
  endfunction

endpackage

### rtl/pel_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pel_pack.sv
// expands 5-bit channels to 8 bits and packs normal and shadow colour words
// depends on pel_pkg
module pel_pack import pel_pkg::*; (
  input  shift_cfg_t         shift_i,
  input  logic [ChanW-1:0]   red_i,
  input  logic [ChanW-1:0]   green_i,
  input  logic [ChanW-1:0]   blue_i,
  output logic [ColourW-1:0] colour_o,
  output logic [ColourW-1:0] shadow_o
);

  logic [7:0] red_x, green_x, blue_x;
  logic [7:0] red_s, green_s, blue_s;

  always_comb begin
    red_x   = expand5(red_i);
    green_x = expand5(green_i);
    blue_x  = expand5(blue_i);
    red_s   = shade8(red_x);
    green_s = shade8(green_x);
    blue_s  = shade8(blue_x);
  end

  // overlapping channels are ored, bits above the top are dropped
  assign colour_o = (ColourW'(red_x) << shift_i.red) |
                    (ColourW'(green_x) << shift_i.green) |
                    (ColourW'(blue_x) << shift_i.blue);
  assign shadow_o = (ColourW'(red_s) << shift_i.red) |
                    (ColourW'(green_s) << shift_i.green) |
                    (ColourW'(blue_s) << shift_i.blue);

endmodule

### rtl/palette_expand_and_lookup.sv
// palette ram with shadow copies: top level
// depends on pel_pkg, pel_pack and pel_ram
//
// Takes one word per clock unless out_ready_i stalls the output. The result word of a
// lookup passes through the input register and the colour register, then the
// registered ram read. The sustained rate is one word per clock unless out_ready_i stalls.
// Writes give no result. A palette write stores the expanded colour in the normal ram
// and the shaded colour in the shadow ram. The shadow ram serves both the shadow and
// the highlight thirds of the lookup range. Each ram has one write and one read port.
// Only one word occupies the ram stage per cycle, so a lookup always sees every
// write taken before it. The rams have no clearing pass: an entry that was never
// written reads as whatever the ram holds. Lookup indexes are masked with
// 3*PALETTE_ENTRIES-1, and write entries wrap modulo PALETTE_ENTRIES. The user must
// write shift registers only while the block is idle; the block does not enforce it.
module palette_expand_and_lookup import pel_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [ShiftW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [12:0]         palette_address_i,
  input  logic [ChanW-1:0]    red_in_i,
  input  logic [ChanW-1:0]    green_in_i,
  input  logic [ChanW-1:0]    blue_in_i,
  input  logic [15:0]         pixel_index_i,
  input  logic                frame_end_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ColourW-1:0]  packed_colour_o,
  output logic                frame_end_out_o
);

  localparam int unsigned EntW   = $clog2(PALETTE_ENTRIES);
  localparam int unsigned IdxW   = $clog2(3 * PALETTE_ENTRIES);
  localparam int unsigned Shift  = EntryW + EntW;
  localparam int unsigned Recip  = ((2 ** Shift) + PALETTE_ENTRIES - 1) / PALETTE_ENTRIES;
  localparam int unsigned RecipW = $clog2(Recip + 1);
  localparam int unsigned ProdW  = EntryW + RecipW + 1;
  localparam logic [IdxW-1:0] IdxMask = IdxW'(3 * PALETTE_ENTRIES - 1);
  localparam logic [IdxW:0]   Third   = (IdxW + 1)'(PALETTE_ENTRIES);
  localparam logic [IdxW:0]   TwoThird = (IdxW + 1)'(2 * PALETTE_ENTRIES);

  // shift registers
  shift_cfg_t shift_q, shift_d;

  // stage 1: input register
  logic              s1_valid_q, s1_valid_d;
  cmd_e              s1_cmd_q;
  logic [EntryW-1:0] s1_entry_q;
  logic [ChanW-1:0]  s1_red_q, s1_green_q, s1_blue_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic              s1_fe_q;

  // stage 2: packed colours, entry quotient, read address
  logic               s2_valid_q, s2_valid_d;
  cmd_e               s2_cmd_q;
  logic [EntryW-1:0]  s2_entry_q;
  logic [EntryW-1:0]  s2_quot_q;
  logic [ColourW-1:0] s2_colour_q, s2_shadow_q;
  logic [EntW-1:0]    s2_raddr_q;
  logic               s2_sel_q;
  logic               s2_fe_q;

  // stage 3: ram read data
  logic s3_valid_q, s3_valid_d;
  logic s3_sel_q;
  logic s3_fe_q;

  logic s1_ready, s2_ready, s3_ready;
  logic ram_we, ram_re;

  logic [ColourW-1:0] pack_colour, pack_shadow;
  logic [ProdW-1:0]   recip_prod;
  logic [EntryW-1:0]  quot;
  logic [ProdW-1:0]   quot_n;
  logic [EntW-1:0]    wr_addr;
  logic [IdxW:0]      idx_ext;
  logic [EntW-1:0]    rd_addr;
  logic               rd_sel;
  logic [ColourW-1:0] norm_rdata, shad_rdata;

  always_comb begin
    shift_d = shift_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RED_SHIFT:   shift_d.red   = cfg_wdata_i;
        CFG_GREEN_SHIFT: shift_d.green = cfg_wdata_i;
        CFG_BLUE_SHIFT:  shift_d.blue  = cfg_wdata_i;
        default:         shift_d = shift_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q.red   <= ShiftW'(16);
      shift_q.green <= ShiftW'(8);
      shift_q.blue  <= ShiftW'(0);
    end else begin
      shift_q <= shift_d;
    end
  end

  // handshake chain, writes leave at stage 2
  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || (s2_cmd_q == CMD_WRITE) || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign ram_we = s2_valid_q && (s2_cmd_q == CMD_WRITE);
  assign ram_re = s2_valid_q && (s2_cmd_q == CMD_LOOKUP) && s3_ready;

  always_comb begin
    s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
    s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;
    s3_valid_d = s3_ready ? ram_re : s3_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_cmd_q   <= cmd_e'(command_i);
      s1_entry_q <= palette_address_i[12:1];
      s1_red_q   <= red_in_i;
      s1_green_q <= green_in_i;
      s1_blue_q  <= blue_in_i;
      s1_idx_q   <= pixel_index_i[IdxW-1:0] & IdxMask;
      s1_fe_q    <= frame_end_in_i;
    end
  end

  pel_pack u_pack (
    .shift_i  (shift_q),
    .red_i    (s1_red_q),
    .green_i  (s1_green_q),
    .blue_i   (s1_blue_q),
    .colour_o (pack_colour),
    .shadow_o (pack_shadow)
  );

  // entry / PALETTE_ENTRIES by reciprocal, exact for 12-bit entries
  assign recip_prod = ProdW'(s1_entry_q) * ProdW'(Recip);
  assign quot       = EntryW'(recip_prod >> Shift);

  always_comb begin
    idx_ext = {1'b0, s1_idx_q};
    priority if (idx_ext < Third) begin
      rd_addr = EntW'(idx_ext);
      rd_sel  = 1'b0;
    end else if (idx_ext < TwoThird) begin
      rd_addr = EntW'(idx_ext - Third);
      rd_sel  = 1'b1;
    end else begin
      rd_addr = EntW'(idx_ext - TwoThird);
      rd_sel  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_cmd_q    <= s1_cmd_q;
      s2_entry_q  <= s1_entry_q;
      s2_quot_q   <= quot;
      s2_colour_q <= pack_colour;
      s2_shadow_q <= pack_shadow;
      s2_raddr_q  <= rd_addr;
      s2_sel_q    <= rd_sel;
      s2_fe_q     <= s1_fe_q;
    end
  end

  assign quot_n  = ProdW'(s2_quot_q) * ProdW'(PALETTE_ENTRIES);
  assign wr_addr = EntW'(ProdW'(s2_entry_q) - quot_n);

  pel_ram #(
    .WIDTH (ColourW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_norm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (s2_colour_q),
    .re_i    (ram_re),
    .raddr_i (s2_raddr_q),
    .rdata_o (norm_rdata)
  );

  pel_ram #(
    .WIDTH (ColourW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_shad_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (s2_shadow_q),
    .re_i    (ram_re),
    .raddr_i (s2_raddr_q),
    .rdata_o (shad_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s3_sel_q <= s2_sel_q;
      s3_fe_q  <= s2_fe_q;
    end
  end

  assign out_valid_o     = s3_valid_q;
  assign packed_colour_o = s3_sel_q ? shad_rdata : norm_rdata;
  assign frame_end_out_o = s3_fe_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ram written and read in the same cycle");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(wr_addr) < PALETTE_ENTRIES))
    else $error("palette write entry out of range");

  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> s3_valid_q)
    else $error("lookup read did not reach result stage");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

endmodule
